// ----- rtl/gf2ils_pkg.sv -----
package gf2ils_pkg;

  localparam int ROW_W  = 64;
  localparam int PIV_W  = 6;
  localparam int RANK_W = 7;
  localparam int CFG_W  = 7;

  // lowest-set-bit search works one byte group per cycle
  localparam int GRP_W     = 8;
  localparam int SUB_W     = $clog2(GRP_W);
  localparam int GRP_IDX_W = PIV_W - SUB_W;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_SOLVE = 1'b1
  } gf2ils_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED,
    ST_FIND,
    ST_ELIM,
    ST_APPEND,
    ST_ADD_RES,
    ST_SCAN,
    ST_FREE,
    ST_COL,
    ST_VEC,
    ST_NOFREE
  } gf2ils_state_e;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [PIV_W-1:0] piv;
    logic             rhs;
  } gf2ils_entry_t;

  typedef struct packed {
    logic             start;
    logic [ROW_W-1:0] row;
  } gf2ils_find_req_t;

  typedef struct packed {
    logic             done;
    logic [PIV_W-1:0] idx;
  } gf2ils_find_rsp_t;

endpackage

// ----- rtl/gf2_incremental_linear_solver.sv -----
// Channel  | Valid         | Stall         | Payload
// request  | in_valid_i    | in_stall_o    | op_i, coefficient_row_i, right_hand_bit_i
// result   | out_valid_o   | out_stall_i   | consistent_o, rank_now_o, assignment_o,
//          |               |               | basis_vector_o, basis_valid_o, last_o
// config   | cfg_wr_en_i   | -             | cfg_wr_data_i (variables_in_use)
//
// Add: a row-memory pass to reduce; if the reduced row is not zero, a byte-wise pivot search,
// a pass to eliminate and an append; then the result.
// Solve: a pass to collect pivots, then a step per pivot variable and, per free variable,
// a walk of the row memory and a result.
// One request at a time; in_stall_o is high while it is in progress. Reset clears the rank
// and sets variables_in_use to 64, no memory clearing pass. A stalled result holds the engine.
module gf2_incremental_linear_solver #(
  parameter int MAX_VARS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_wr_en_i,
  input  logic [gf2ils_pkg::CFG_W-1:0]       cfg_wr_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               op_i,
  input  logic [gf2ils_pkg::ROW_W-1:0]       coefficient_row_i,
  input  logic                               right_hand_bit_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               consistent_o,
  output logic [gf2ils_pkg::RANK_W-1:0]      rank_now_o,
  output logic [gf2ils_pkg::ROW_W-1:0]       assignment_o,
  output logic [gf2ils_pkg::ROW_W-1:0]       basis_vector_o,
  output logic                               basis_valid_o,
  output logic                               last_o
);
  import gf2ils_pkg::*;

  localparam int AW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam logic [RANK_W-1:0] MaxVarsW = RANK_W'(MAX_VARS);

  gf2ils_state_e state_q, state_d;

  logic [CFG_W-1:0]  vars_q;
  logic [RANK_W-1:0] rank_q, rank_d;
  logic [RANK_W-1:0] cnt_q, cnt_d;
  logic              rd_vld_q, rd_vld_d;
  logic [AW-1:0]     rd_addr_q, rd_addr_d;
  gf2ils_entry_t     rdata_q;

  logic [ROW_W-1:0]  acc_row_q, acc_row_d;
  logic              acc_rhs_q, acc_rhs_d;
  logic [PIV_W-1:0]  piv_q, piv_d;
  logic              cons_q, cons_d;
  logic [ROW_W-1:0]  pivset_q, pivset_d;
  logic [ROW_W-1:0]  asg_q, asg_d;
  logic [RANK_W-1:0] var_q, var_d;
  logic [ROW_W-1:0]  vec_q, vec_d;

  logic              out_vld_q;
  logic              out_load;
  logic              out_free;
  logic              out_cons_d;
  logic [ROW_W-1:0]  out_asg_d, out_vec_d;
  logic              out_bvalid_d, out_last_d;
  logic              out_cons_q;
  logic [RANK_W-1:0] out_rank_q;
  logic [ROW_W-1:0]  out_asg_q, out_vec_q;
  logic              out_bvalid_q, out_last_q;

  gf2ils_entry_t     mem [MAX_VARS];
  logic              mem_re, mem_we;
  logic [AW-1:0]     mem_raddr, mem_waddr;
  gf2ils_entry_t     mem_wdata;

  gf2ils_find_req_t  find_req;
  gf2ils_find_rsp_t  find_rsp;

  logic [RANK_W-1:0] n_act;
  logic [ROW_W-1:0]  var_mask;
  logic [ROW_W-1:0]  free_above;
  logic              last_vec;
  logic              in_acc;
  logic              pass_st;
  logic              issue;
  logic              pass_end;
  logic              can_append;

  gf2ils_lsb_find u_find (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (find_req),
    .rsp_o  (find_rsp)
  );

  // clamp the unknown count to 1..MAX_VARS
  always_comb begin
    priority if (vars_q == '0) begin
      n_act = RANK_W'(1);
    end else if (vars_q > MaxVarsW) begin
      n_act = MaxVarsW;
    end else begin
      n_act = vars_q;
    end
  end

  always_comb begin
    for (int k = 0; k < ROW_W; k++) begin
      var_mask[k]   = (RANK_W'(k) < n_act);
      free_above[k] = (RANK_W'(k) > var_q) && var_mask[k] && !pivset_q[k];
    end
  end

  assign last_vec   = (free_above == '0);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pass_st    = (state_q == ST_RED) || (state_q == ST_ELIM) ||
                      (state_q == ST_SCAN) || (state_q == ST_COL);
  assign issue      = pass_st && (cnt_q < rank_q);
  assign pass_end   = !issue && !rd_vld_q;
  assign out_free   = !out_vld_q || !out_stall_i;
  assign can_append = (rank_q < MaxVarsW);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (op_i == OP_ADD) ? ST_RED : ST_SCAN;
        end
      end
      ST_RED: begin
        if (pass_end) begin
          state_d = (acc_row_q == '0) ? ST_ADD_RES : ST_FIND;
        end
      end
      ST_FIND: begin
        if (find_rsp.done) begin
          state_d = ST_ELIM;
        end
      end
      ST_ELIM: begin
        if (pass_end) begin
          state_d = ST_APPEND;
        end
      end
      ST_APPEND:  state_d = ST_ADD_RES;
      ST_ADD_RES: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (pass_end) begin
          state_d = ST_FREE;
        end
      end
      ST_FREE: begin
        if (var_q >= n_act) begin
          state_d = ST_NOFREE;
        end else if (!pivset_q[var_q[PIV_W-1:0]]) begin
          state_d = ST_COL;
        end
      end
      ST_COL: begin
        if (pass_end) begin
          state_d = ST_VEC;
        end
      end
      ST_VEC: begin
        if (out_free) begin
          state_d = last_vec ? ST_IDLE : ST_FREE;
        end
      end
      ST_NOFREE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory strobes, search start and request stall
  always_comb begin
    in_stall_o     = (state_q != ST_IDLE);
    mem_re         = issue;
    mem_raddr      = cnt_q[AW-1:0];
    mem_we         = 1'b0;
    mem_waddr      = rd_addr_q;
    mem_wdata      = rdata_q;
    find_req.start = (state_q == ST_RED) && pass_end && (acc_row_q != '0);
    find_req.row   = acc_row_q;
    if ((state_q == ST_ELIM) && rd_vld_q && rdata_q.row[piv_q]) begin
      mem_we        = 1'b1;
      mem_waddr     = rd_addr_q;
      mem_wdata.row = rdata_q.row ^ acc_row_q;
      mem_wdata.piv = rdata_q.piv;
      mem_wdata.rhs = rdata_q.rhs ^ acc_rhs_q;
    end else if ((state_q == ST_APPEND) && can_append) begin
      mem_we        = 1'b1;
      mem_waddr     = rank_q[AW-1:0];
      mem_wdata.row = acc_row_q;
      mem_wdata.piv = piv_q;
      mem_wdata.rhs = acc_rhs_q;
    end
  end

  // datapath
  always_comb begin
    rank_d       = rank_q;
    cnt_d        = cnt_q;
    rd_vld_d     = 1'b0;
    rd_addr_d    = cnt_q[AW-1:0];
    acc_row_d    = acc_row_q;
    acc_rhs_d    = acc_rhs_q;
    piv_d        = piv_q;
    cons_d       = cons_q;
    pivset_d     = pivset_q;
    asg_d        = asg_q;
    var_d        = var_q;
    vec_d        = vec_q;
    out_load     = 1'b0;
    out_cons_d   = 1'b0;
    out_asg_d    = '0;
    out_vec_d    = '0;
    out_bvalid_d = 1'b0;
    out_last_d   = 1'b1;

    // advance the row walk
    if (issue) begin
      cnt_d    = cnt_q + 1'b1;
      rd_vld_d = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_d     = '0;
          acc_row_d = coefficient_row_i & var_mask;
          acc_rhs_d = right_hand_bit_i;
          pivset_d  = '0;
          asg_d     = '0;
        end
      end
      ST_RED: begin
        if (rd_vld_q && acc_row_q[rdata_q.piv]) begin
          acc_row_d = acc_row_q ^ rdata_q.row;
          acc_rhs_d = acc_rhs_q ^ rdata_q.rhs;
        end
        if (pass_end) begin
          cons_d = !acc_rhs_q;
        end
      end
      ST_FIND: begin
        if (find_rsp.done) begin
          piv_d = find_rsp.idx;
          cnt_d = '0;
        end
      end
      ST_ELIM: ;
      ST_APPEND: begin
        cons_d = 1'b1;
        if (can_append) begin
          rank_d = rank_q + 1'b1;
        end
      end
      ST_ADD_RES: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_cons_d = cons_q;
        end
      end
      ST_SCAN: begin
        if (rd_vld_q) begin
          pivset_d = pivset_q | (ROW_W'(1) << rdata_q.piv);
          if (rdata_q.rhs) begin
            asg_d = asg_q | (ROW_W'(1) << rdata_q.piv);
          end
        end
        if (pass_end) begin
          var_d = '0;
        end
      end
      ST_FREE: begin
        if (var_q < n_act) begin
          if (pivset_q[var_q[PIV_W-1:0]]) begin
            var_d = var_q + 1'b1;
          end else begin
            vec_d = ROW_W'(1) << var_q[PIV_W-1:0];
            cnt_d = '0;
          end
        end
      end
      ST_COL: begin
        if (rd_vld_q && rdata_q.row[var_q[PIV_W-1:0]]) begin
          vec_d = vec_q | (ROW_W'(1) << rdata_q.piv);
        end
      end
      ST_VEC: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_asg_d    = asg_q & var_mask;
          out_vec_d    = vec_q & var_mask;
          out_bvalid_d = 1'b1;
          out_last_d   = last_vec;
          var_d        = var_q + 1'b1;
        end
      end
      ST_NOFREE: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_asg_d = asg_q & var_mask;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vars_q    <= CFG_W'(64);
      rank_q    <= '0;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rank_q   <= rank_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
      if (cfg_wr_en_i) begin
        vars_q <= cfg_wr_data_i;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    acc_row_q <= acc_row_d;
    acc_rhs_q <= acc_rhs_d;
    piv_q     <= piv_d;
    cons_q    <= cons_d;
    pivset_q  <= pivset_d;
    asg_q     <= asg_d;
    var_q     <= var_d;
    vec_q     <= vec_d;
    if (out_load) begin
      out_cons_q   <= out_cons_d;
      out_rank_q   <= rank_q;
      out_asg_q    <= out_asg_d;
      out_vec_q    <= out_vec_d;
      out_bvalid_q <= out_bvalid_d;
      out_last_q   <= out_last_d;
    end
  end

  // row memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o    = out_vld_q;
  assign consistent_o   = out_cons_q;
  assign rank_now_o     = out_rank_q;
  assign assignment_o   = out_asg_q;
  assign basis_vector_o = out_vec_q;
  assign basis_valid_o  = out_bvalid_q;
  assign last_o         = out_last_q;

endmodule

// ----- rtl/gf2ils_lsb_find.sv -----
module gf2ils_lsb_find (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gf2ils_pkg::gf2ils_find_req_t req_i,
  output gf2ils_pkg::gf2ils_find_rsp_t rsp_o
);
  import gf2ils_pkg::*;

  logic                 busy_q;
  logic [GRP_IDX_W-1:0] grp_q;
  logic [ROW_W-1:0]     row_q;
  logic [GRP_W-1:0]     grp_bits;
  logic [SUB_W-1:0]     sub_idx;
  logic                 hit;

  assign grp_bits = row_q[GRP_W*grp_q +: GRP_W];
  assign hit      = busy_q && (grp_bits != '0);

  // lowest set bit inside the current group
  always_comb begin
    sub_idx = '0;
    for (int k = GRP_W - 1; k >= 0; k--) begin
      if (grp_bits[k]) begin
        sub_idx = SUB_W'(k);
      end
    end
  end

  assign rsp_o.done = hit;
  assign rsp_o.idx  = {grp_q, sub_idx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      grp_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      grp_q  <= '0;
    end else if (hit) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      grp_q <= grp_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      row_q <= req_i.row;
    end
  end

endmodule

// ----- sim/gf2ils_result_checker.sv -----
module gf2ils_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wr_en_i,
  input  logic [gf2ils_pkg::CFG_W-1:0]  cfg_wr_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          op_i,
  input  logic [gf2ils_pkg::ROW_W-1:0]  coefficient_row_i,
  input  logic                          right_hand_bit_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          consistent_i,
  input  logic [gf2ils_pkg::RANK_W-1:0] rank_now_i,
  input  logic [gf2ils_pkg::ROW_W-1:0]  assignment_i,
  input  logic [gf2ils_pkg::ROW_W-1:0]  basis_vector_i,
  input  logic                          basis_valid_i,
  input  logic                          last_i,
  output int                            outstanding_o,
  output int                            fail_count_o
);
  import gf2ils_pkg::*;

  localparam int MAX_VARS = 64;

  typedef struct packed {
    logic              consistent;
    logic [RANK_W-1:0] rank_now;
    logic [ROW_W-1:0]  assignment;
    logic [ROW_W-1:0]  basis_vector;
    logic              basis_valid;
    logic              last;
  } solver_result_t;

  logic [ROW_W-1:0] echelon_rows [MAX_VARS];
  logic [PIV_W-1:0] echelon_pivots [MAX_VARS];
  logic             echelon_rhs [MAX_VARS];
  int unsigned      echelon_rank;
  logic [CFG_W-1:0] unknowns_cfg;
  solver_result_t   pending_results [$];
  int               mismatches = 0;

  assign fail_count_o = mismatches;

  // zero unknowns counts as one, anything above the row width saturates
  function automatic int unsigned active_unknowns();
    if (unknowns_cfg == '0) return 1;
    if (unknowns_cfg > MAX_VARS) return MAX_VARS;
    return unknowns_cfg;
  endfunction

  function automatic logic [ROW_W-1:0] unknown_mask(input int unsigned n);
    if (n >= ROW_W) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic void queue_result(input solver_result_t res);
    pending_results.insert(pending_results.size(), res);
  endfunction

  task automatic absorb_equation(input logic [ROW_W-1:0] coeffs, input logic rhs);
    logic [ROW_W-1:0] row;
    logic             row_rhs;
    int unsigned      i;
    int unsigned      piv;
    solver_result_t   res;
    row = coeffs & unknown_mask(active_unknowns());
    row_rhs = rhs;
    for (i = 0; i < echelon_rank; i++) begin
      if (row[echelon_pivots[i]]) begin
        row ^= echelon_rows[i];
        row_rhs ^= echelon_rhs[i];
      end
    end
    res = '0;
    res.last = 1'b1;
    if (row == '0) begin
      res.consistent = !row_rhs;
    end else begin
      piv = 0;
      while (!row[piv]) piv++;
      // clear the new pivot from every stored row to keep the basis fully reduced
      for (i = 0; i < echelon_rank; i++) begin
        if (echelon_rows[i][piv]) begin
          echelon_rows[i] ^= row;
          echelon_rhs[i] ^= row_rhs;
        end
      end
      if (echelon_rank < MAX_VARS) begin
        echelon_rows[echelon_rank] = row;
        echelon_pivots[echelon_rank] = piv[PIV_W-1:0];
        echelon_rhs[echelon_rank] = row_rhs;
        echelon_rank++;
      end
      res.consistent = 1'b1;
    end
    res.rank_now = echelon_rank[RANK_W-1:0];
    queue_result(res);
  endtask

  task automatic predict_solution();
    int unsigned      n;
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] particular;
    logic [ROW_W-1:0] pivot_set;
    logic [ROW_W-1:0] vec;
    int unsigned      i;
    int unsigned      j;
    solver_result_t   held;
    logic             have_held;
    n = active_unknowns();
    mask = unknown_mask(n);
    particular = '0;
    pivot_set = '0;
    have_held = 1'b0;
    held = '0;
    for (j = 0; j < echelon_rank; j++) begin
      pivot_set[echelon_pivots[j]] = 1'b1;
      if (echelon_rhs[j]) particular[echelon_pivots[j]] = 1'b1;
    end
    particular &= mask;
    for (i = 0; i < n; i++) begin
      if (!pivot_set[i]) begin
        vec = 64'd1 << i;
        for (j = 0; j < echelon_rank; j++) begin
          if (echelon_rows[j][i]) vec[echelon_pivots[j]] = 1'b1;
        end
        // hold each vector back one step so the final one can carry last
        if (have_held) queue_result(held);
        held = '0;
        held.rank_now = echelon_rank[RANK_W-1:0];
        held.assignment = particular;
        held.basis_vector = vec & mask;
        held.basis_valid = 1'b1;
        have_held = 1'b1;
      end
    end
    if (!have_held) begin
      held = '0;
      held.rank_now = echelon_rank[RANK_W-1:0];
      held.assignment = particular;
    end
    held.last = 1'b1;
    queue_result(held);
  endtask

  function automatic void check_field(input string field, input logic [ROW_W-1:0] want,
                                      input logic [ROW_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", field, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_result();
    solver_result_t want;
    if (pending_results.size() == 0) begin
      $error("result arrived with no request outstanding");
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    check_field("consistent", want.consistent, consistent_i);
    check_field("rank_now", want.rank_now, rank_now_i);
    check_field("assignment", want.assignment, assignment_i);
    check_field("basis_vector", want.basis_vector, basis_vector_i);
    check_field("basis_valid", want.basis_valid, basis_valid_i);
    check_field("last", want.last, last_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echelon_rank = 0;
      unknowns_cfg = 7'd64;
      pending_results.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_wr_en_i) unknowns_cfg = cfg_wr_data_i;
      if (in_valid_i && !in_stall_i) begin
        if (op_i == OP_SOLVE) predict_solution();
        else absorb_equation(coefficient_row_i, right_hand_bit_i);
      end
      if (out_valid_i && !out_stall_i) check_result();
      outstanding_o <= pending_results.size();
    end
  end

endmodule

// ----- sim/gf2_incremental_linear_solver_test.sv -----
module gf2_incremental_linear_solver_test;
  import gf2ils_pkg::*;

  localparam int SETTLE_CYCLES  = 20;
  localparam int TAIL_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 5000;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_wr_en_i;
  logic [CFG_W-1:0]  cfg_wr_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              op_i;
  logic [ROW_W-1:0]  coefficient_row_i;
  logic              right_hand_bit_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              consistent_o;
  logic [RANK_W-1:0] rank_now_o;
  logic [ROW_W-1:0]  assignment_o;
  logic [ROW_W-1:0]  basis_vector_o;
  logic              basis_valid_o;
  logic              last_o;

  int                results_outstanding;
  int                result_mismatches;
  logic              steady;
  logic [ROW_W:0]    equation_log [$];

  gf2_incremental_linear_solver dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_wr_en_i       (cfg_wr_en_i),
    .cfg_wr_data_i     (cfg_wr_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .coefficient_row_i (coefficient_row_i),
    .right_hand_bit_i  (right_hand_bit_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .consistent_o      (consistent_o),
    .rank_now_o        (rank_now_o),
    .assignment_o      (assignment_o),
    .basis_vector_o    (basis_vector_o),
    .basis_valid_o     (basis_valid_o),
    .last_o            (last_o)
  );

  gf2ils_result_checker checker_u (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_wr_en_i       (cfg_wr_en_i),
    .cfg_wr_data_i     (cfg_wr_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .op_i              (op_i),
    .coefficient_row_i (coefficient_row_i),
    .right_hand_bit_i  (right_hand_bit_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .consistent_i      (consistent_o),
    .rank_now_i        (rank_now_o),
    .assignment_i      (assignment_o),
    .basis_vector_i    (basis_vector_o),
    .basis_valid_i     (basis_valid_o),
    .last_i            (last_o),
    .outstanding_o     (results_outstanding),
    .fail_count_o      (result_mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !steady && ($urandom_range(99) < 33);
    end
  end

  function automatic void log_equation(input logic [ROW_W:0] entry);
    equation_log.insert(equation_log.size(), entry);
  endfunction

  // leaves valid high so back-to-back requests need no second assignment
  task automatic send_request(input gf2ils_op_e kind, input logic [ROW_W-1:0] coeffs,
                              input logic rhs);
    if (!steady && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= kind;
    coefficient_row_i <= coeffs;
    right_hand_bit_i <= rhs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (kind == OP_ADD) log_equation({rhs, coeffs});
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_unknowns(input logic [CFG_W-1:0] value);
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] unknowns, input int items);
    logic [ROW_W-1:0] coeffs;
    logic [ROW_W:0]   mix;
    logic             rhs;
    int               k;
    wait_drained();
    write_unknowns(unknowns);
    for (k = 0; k < items; k++) begin
      if ($urandom_range(99) < 15) begin
        send_request(OP_SOLVE, {$urandom, $urandom}, 1'($urandom));
      end else begin
        if (equation_log.size() > 1 && $urandom_range(99) < 25) begin
          // combine earlier equations: redundant, or contradictory with rhs flipped
          mix = '0;
          repeat ($urandom_range(2, 3))
            mix ^= equation_log[$urandom_range(equation_log.size() - 1)];
          coeffs = mix[ROW_W-1:0];
          rhs = mix[ROW_W] ^ ($urandom_range(99) < 30);
        end else if ($urandom_range(1)) begin
          coeffs = {$urandom, $urandom};
          rhs = 1'($urandom);
        end else begin
          coeffs = '0;
          repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(3) != 0) coeffs[$urandom_range(unknowns - 1)] = 1'b1;
            else coeffs[$urandom_range(ROW_W - 1)] = 1'b1;
          end
          rhs = 1'($urandom);
        end
        send_request(OP_ADD, coeffs, rhs);
      end
      // let the block run dry now and then
      if ($urandom_range(99) < 4) wait_drained();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_wr_en_i = 1'b0;
    cfg_wr_data_i = '0;
    in_valid_i = 1'b0;
    op_i = OP_ADD;
    coefficient_row_i = '0;
    right_hand_bit_i = 1'b0;
    steady = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store: every unknown is free
    send_request(OP_SOLVE, '0, 1'b0);
    send_request(OP_ADD, '1, 1'b1);
    send_request(OP_ADD, 64'h8000_0000_0000_0000, 1'b0);
    send_request(OP_ADD, '0, 1'b0);
    send_request(OP_ADD, '0, 1'b1);
    send_request(OP_ADD, '1, 1'b1);
    send_request(OP_ADD, '1, 1'b0);
    send_request(OP_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    send_request(OP_SOLVE, '1, 1'b1);

    // zero unknowns acts as one: upper bits vanish, no free variable left
    wait_drained();
    write_unknowns(7'd0);
    send_request(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
    send_request(OP_SOLVE, '0, 1'b0);

    // oversized count saturates to the full row
    wait_drained();
    write_unknowns(7'd127);
    send_request(OP_ADD, 64'h4000_0000_0000_0000, 1'b1);
    send_request(OP_SOLVE, '0, 1'b0);

    // shrink after adds: high pivots drop out of the solution
    wait_drained();
    write_unknowns(7'd8);
    send_request(OP_SOLVE, '0, 1'b0);
    send_request(OP_ADD, 64'h0000_0000_0000_FF00, 1'b1);
    send_request(OP_ADD, 64'h0000_0000_0000_0006, 1'b0);
    send_request(OP_SOLVE, '0, 1'b0);

    run_phase(7'd3, 20);
    run_phase(7'd1, 10);
    steady <= 1'b1;
    run_phase(7'd16, 25);
    steady <= 1'b0;
    run_phase(7'd5, 15);
    run_phase(7'd40, 30);
    run_phase(7'd64, 50);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (result_mismatches == 0 && results_outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          cfg_wr_en_i) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Verification failed");
    $finish;
  end

endmodule
